### sv/hcp_pkg.sv
// Package for the HSV color picker controller: widths, codes, reset values and helpers.
package hcp_pkg;

   // Field widths
   localparam int HUE_W      = 9;
   localparam int LVL_W      = 8;
   localparam int CNT_W      = 9;
   localparam int REQ_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int STEP_W     = 4;

   // Configuration reset values
   localparam logic [HUE_W-1:0] HUE_MOD_RST  = 9'd360;
   localparam logic [LVL_W-1:0] SAT_MAX_RST  = 8'd100;
   localparam logic [LVL_W-1:0] VAL_MAX_RST  = 8'd100;
   localparam logic [LVL_W-1:0] MAX_DUTY_RST = 8'd100;

   // Top shift position of the divisor while reducing the blink counter
   localparam logic [STEP_W-1:0] DIV_TOP_STEP = 4'd8;

   // Item request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_MODE = 3'd0,
      REQ_STEP = 3'd1,
      REQ_TICK = 3'd2,
      REQ_SET  = 3'd3,
      REQ_LOAD = 3'd4
   } req_code_type;

   // Picker modes
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_HUE  = 2'd1,
      MODE_SAT  = 2'd2,
      MODE_VAL  = 2'd3
   } mode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_MOD  = 2'd0,
      CSR_SAT_MAX  = 2'd1,
      CSR_VAL_MAX  = 2'd2,
      CSR_MAX_DUTY = 2'd3
   } csr_idx_type;

   // Sequencer that reduces the blink counter after a duty change
   typedef enum logic [1:0] {
      SEQ_RUN    = 2'b01,
      SEQ_REDUCE = 2'b10
   } seq_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             down;
   } bounce_type;

   // One back-and-forth step of a level between 0 and top
   function automatic bounce_type bounce(input logic [LVL_W-1:0] level,
                                         input logic             down,
                                         input logic [LVL_W-1:0] top);
      bounce_type r;
      logic       nd;
      nd = down ^ ((!down && (level >= top)) || (down && (level == '0)));
      r.down = nd;
      if (nd) begin
         r.level = (level != '0) ? level - 1'b1 : '0;
      end else begin
         r.level = (level != '1) ? level + 1'b1 : '1;
      end
      return r;
   endfunction

   // Clamp a level to its top
   function automatic logic [LVL_W-1:0] clamp_lvl(input logic [LVL_W-1:0] v,
                                                  input logic [LVL_W-1:0] top);
      return (v > top) ? top : v;
   endfunction

endpackage

### sv/hsv_color_picker_mode_fsm_top.sv
// Top level of the HSV color picker controller: state, result register and counter reduction.
//
//   channel | ports                         | direction | accepted when
//   --------+-------------------------------+-----------+-----------------------
//   request | req_valid/req_ready, fields   | in        | req_valid & req_ready
//   result  | rsp_valid/rsp_ready, fields   | out       | rsp_valid & rsp_ready
//   csr     | csr_wr_en, csr_index, csr_data| in        | csr_wr_en
//
// One item per cycle while req_ready is high; its result is registered and shows in the cycle after acceptance.
// A new item is taken while the result register is empty or being drained.
// A write of max_duty starts a reduction of the blink counter (one
// compare-subtract per cycle); req_ready is low while the reduction runs.
// Reset is synchronous: config returns to its defaults, picker state and the result valid flag clear.
module hsv_color_picker_mode_fsm_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hcp_pkg::REQ_W-1:0]          req_type,
   input  logic [hcp_pkg::HUE_W-1:0]          req_hue_in,
   input  logic [hcp_pkg::LVL_W-1:0]          req_sat_in,
   input  logic [hcp_pkg::LVL_W-1:0]          req_val_in,
   input  logic                               req_sat_down_in,
   input  logic                               req_val_down_in,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_mode,
   output logic [hcp_pkg::HUE_W-1:0]          rsp_hue,
   output logic [hcp_pkg::LVL_W-1:0]          rsp_sat,
   output logic [hcp_pkg::LVL_W-1:0]          rsp_val,
   output logic                               rsp_sat_down,
   output logic                               rsp_val_down,
   output logic [hcp_pkg::LVL_W-1:0]          rsp_duty,
   // configuration port
   input  logic                               csr_wr_en,
   input  logic [hcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hcp_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Configuration registers
   logic [hcp_pkg::HUE_W-1:0] hue_mod_ff;
   logic [hcp_pkg::LVL_W-1:0] sat_max_ff, val_max_ff, max_duty_ff;

   // Picker state
   hcp_pkg::mode_type         mode_ff, mode_in;
   logic [hcp_pkg::HUE_W-1:0] hue_ff, hue_in;
   logic [hcp_pkg::LVL_W-1:0] sat_ff, sat_in, val_ff, val_in;
   logic                      sat_down_ff, sat_down_in, val_down_ff, val_down_in;
   logic [hcp_pkg::CNT_W-1:0] blink_ff, blink_in;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   hcp_pkg::mode_type         rsp_mode_ff;
   logic [hcp_pkg::HUE_W-1:0] rsp_hue_ff;
   logic [hcp_pkg::LVL_W-1:0] rsp_sat_ff, rsp_val_ff, rsp_duty_ff, duty_in;
   logic                      rsp_sat_down_ff, rsp_val_down_ff;

   // Reduction sequencer
   hcp_pkg::seq_type           seq_ff, seq_in;
   logic [hcp_pkg::CNT_W:0]    div_rem_ff, div_rem_in;
   logic [hcp_pkg::STEP_W-1:0] div_step_ff, div_step_in;
   logic [hcp_pkg::CNT_W-1:0]  wrap_ff, wrap_in;

   logic                        accept;
   logic                        dw_start;
   logic [hcp_pkg::CNT_W-1:0]   period;
   logic [hcp_pkg::CNT_W:0]     cnt_inc;
   logic [hcp_pkg::HUE_W:0]     hue_inc;
   logic [hcp_pkg::HUE_W-1:0]   hue_top;
   logic [2*hcp_pkg::CNT_W-1:0] div_shift;
   logic                        div_fit;
   logic [hcp_pkg::CNT_W-1:0]   duty_gap;
   logic [hcp_pkg::CNT_W-1:0]   duty_ext;
   hcp_pkg::bounce_type         sat_b, val_b;

   assign req_ready = (seq_ff == hcp_pkg::SEQ_RUN) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign period    = {max_duty_ff, 1'b0};
   assign cnt_inc   = {1'b0, blink_ff} + 1'b1;
   assign hue_inc   = {1'b0, hue_ff} + 1'b1;
   assign hue_top   = (hue_mod_ff != '0) ? hue_mod_ff - 1'b1 : '0;
   assign sat_b     = hcp_pkg::bounce(sat_ff, sat_down_ff, sat_max_ff);
   assign val_b     = hcp_pkg::bounce(val_ff, val_down_ff, val_max_ff);

   // Next picker state for an accepted item
   always_comb begin
      mode_in     = mode_ff;
      hue_in      = hue_ff;
      sat_in      = sat_ff;
      val_in      = val_ff;
      sat_down_in = sat_down_ff;
      val_down_in = val_down_ff;
      blink_in    = blink_ff;
      if (accept) begin
         unique case (req_type)
            hcp_pkg::REQ_MODE: begin
               mode_in  = (mode_ff == hcp_pkg::MODE_VAL) ? hcp_pkg::MODE_IDLE
                                                         : hcp_pkg::mode_type'(mode_ff + 2'd1);
               blink_in = '0;
            end
            hcp_pkg::REQ_STEP: begin
               unique case (mode_ff)
                  hcp_pkg::MODE_HUE: begin
                     hue_in = (hue_inc >= {1'b0, hue_mod_ff}) ? '0
                                                              : hue_inc[hcp_pkg::HUE_W-1:0];
                  end
                  hcp_pkg::MODE_SAT: begin
                     sat_in      = sat_b.level;
                     sat_down_in = sat_b.down;
                  end
                  hcp_pkg::MODE_VAL: begin
                     val_in      = val_b.level;
                     val_down_in = val_b.down;
                  end
                  default: ;
               endcase
            end
            hcp_pkg::REQ_TICK: begin
               if (mode_ff == hcp_pkg::MODE_HUE || mode_ff == hcp_pkg::MODE_SAT) begin
                  priority if (period == '0) begin
                     blink_in = '0;
                  end else if (blink_ff >= period) begin
                     // counter left beyond a shortened period: precomputed remainder
                     blink_in = wrap_ff;
                  end else if (cnt_inc == {1'b0, period}) begin
                     blink_in = '0;
                  end else begin
                     blink_in = cnt_inc[hcp_pkg::CNT_W-1:0];
                  end
               end
            end
            hcp_pkg::REQ_SET, hcp_pkg::REQ_LOAD: begin
               hue_in = (req_hue_in > hue_top) ? hue_top : req_hue_in;
               sat_in = hcp_pkg::clamp_lvl(req_sat_in, sat_max_ff);
               val_in = hcp_pkg::clamp_lvl(req_val_in, val_max_ff);
               if (req_type == hcp_pkg::REQ_LOAD) begin
                  sat_down_in = req_sat_down_in;
                  val_down_in = req_val_down_in;
               end
            end
            default: ;
         endcase
      end
   end

   // Indicator duty from the new state
   always_comb begin
      duty_gap = (blink_in >= {1'b0, max_duty_ff}) ? blink_in - {1'b0, max_duty_ff}
                                                   : {1'b0, max_duty_ff} - blink_in;
      duty_ext = (duty_gap > {1'b0, max_duty_ff}) ? '0 : {1'b0, max_duty_ff} - duty_gap;
      unique case (mode_in)
         hcp_pkg::MODE_IDLE: duty_in = '0;
         hcp_pkg::MODE_VAL:  duty_in = max_duty_ff;
         default:            duty_in = duty_ext[hcp_pkg::LVL_W-1:0];
      endcase
   end

   // Blink counter reduction: one restoring compare-subtract per cycle
   assign dw_start  = csr_wr_en && (csr_index == hcp_pkg::CSR_MAX_DUTY);
   assign div_shift = {{hcp_pkg::CNT_W{1'b0}}, period} << div_step_ff;
   assign div_fit   = {{(hcp_pkg::CNT_W-1){1'b0}}, div_rem_ff} >= div_shift;

   always_comb begin
      seq_in      = seq_ff;
      div_rem_in  = div_rem_ff;
      div_step_in = div_step_ff;
      wrap_in     = wrap_ff;
      if (seq_ff == hcp_pkg::SEQ_REDUCE) begin
         if (div_fit) begin
            div_rem_in = div_rem_ff - div_shift[hcp_pkg::CNT_W:0];
         end
         if (div_step_ff == '0) begin
            seq_in  = hcp_pkg::SEQ_RUN;
            wrap_in = div_rem_in[hcp_pkg::CNT_W-1:0];
         end else begin
            div_step_in = div_step_ff - 1'b1;
         end
      end
      if (dw_start) begin
         seq_in      = hcp_pkg::SEQ_REDUCE;
         div_rem_in  = {1'b0, blink_in} + 1'b1;
         div_step_in = hcp_pkg::DIV_TOP_STEP;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_mod_ff   <= hcp_pkg::HUE_MOD_RST;
         sat_max_ff   <= hcp_pkg::SAT_MAX_RST;
         val_max_ff   <= hcp_pkg::VAL_MAX_RST;
         max_duty_ff  <= hcp_pkg::MAX_DUTY_RST;
         mode_ff      <= hcp_pkg::MODE_IDLE;
         hue_ff       <= '0;
         sat_ff       <= '0;
         val_ff       <= '0;
         sat_down_ff  <= 1'b0;
         val_down_ff  <= 1'b0;
         blink_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         seq_ff       <= hcp_pkg::SEQ_RUN;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               hcp_pkg::CSR_HUE_MOD:  hue_mod_ff  <= csr_data;
               hcp_pkg::CSR_SAT_MAX:  sat_max_ff  <= csr_data[hcp_pkg::LVL_W-1:0];
               hcp_pkg::CSR_VAL_MAX:  val_max_ff  <= csr_data[hcp_pkg::LVL_W-1:0];
               hcp_pkg::CSR_MAX_DUTY: max_duty_ff <= csr_data[hcp_pkg::LVL_W-1:0];
               default: ;
            endcase
         end
         mode_ff      <= mode_in;
         hue_ff       <= hue_in;
         sat_ff       <= sat_in;
         val_ff       <= val_in;
         sat_down_ff  <= sat_down_in;
         val_down_ff  <= val_down_in;
         blink_ff     <= blink_in;
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      div_rem_ff  <= div_rem_in;
      div_step_ff <= div_step_in;
      wrap_ff     <= wrap_in;
      if (accept) begin
         rsp_mode_ff     <= mode_in;
         rsp_hue_ff      <= hue_in;
         rsp_sat_ff      <= sat_in;
         rsp_val_ff      <= val_in;
         rsp_sat_down_ff <= sat_down_in;
         rsp_val_down_ff <= val_down_in;
         rsp_duty_ff     <= duty_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mode     = rsp_mode_ff;
   assign rsp_hue      = rsp_hue_ff;
   assign rsp_sat      = rsp_sat_ff;
   assign rsp_val      = rsp_val_ff;
   assign rsp_sat_down = rsp_sat_down_ff;
   assign rsp_val_down = rsp_val_down_ff;
   assign rsp_duty     = rsp_duty_ff;

   // A duty change holds off items while the counter is reduced
   a_reduce_blocks: assert property (@(posedge clock) disable iff (reset)
      dw_start |=> !req_ready)
      else $error("item accepted during blink counter reduction");

   // A mode step clears the blink counter
   a_mode_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == hcp_pkg::REQ_MODE) |=> (blink_ff == '0))
      else $error("blink counter not cleared by mode step");

   // A hue step keeps hue below the modulus
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_wr_en && (req_type == hcp_pkg::REQ_STEP) && (mode_ff == hcp_pkg::MODE_HUE)
      |=> (hue_ff < hue_mod_ff) || (hue_ff == '0))
      else $error("hue step left hue at or above modulus");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the HSV color picker controller top level.
`timescale 1ns / 100ps

module tb;

   localparam int REQ_W      = hcp_pkg::REQ_W;
   localparam int HUE_W      = hcp_pkg::HUE_W;
   localparam int LVL_W      = hcp_pkg::LVL_W;
   localparam int CNT_W      = hcp_pkg::CNT_W;
   localparam int CSR_IDX_W  = hcp_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = hcp_pkg::CSR_DATA_W;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 5;
   localparam int IDLE_PCT     = 19;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int HOLD_AT      = 700;  // result count at which the receiver holds off
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE       = 12;   // covers the counter reduction
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 230;

   // One input item
   typedef struct {
      logic [REQ_W-1:0] kind;
      logic [HUE_W-1:0] hue;
      logic [LVL_W-1:0] sat;
      logic [LVL_W-1:0] val;
      logic             sat_down;
      logic             val_down;
   } picker_event_type;

   // One result item
   typedef struct {
      logic [1:0]       mode;
      logic [HUE_W-1:0] hue;
      logic [LVL_W-1:0] sat;
      logic [LVL_W-1:0] val;
      logic             sat_down;
      logic             val_down;
      logic [LVL_W-1:0] duty;
   } led_view_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [REQ_W-1:0]      req_type = '0;
   logic [HUE_W-1:0]      req_hue_in = '0;
   logic [LVL_W-1:0]      req_sat_in = '0;
   logic [LVL_W-1:0]      req_val_in = '0;
   logic                  req_sat_down_in = 1'b0;
   logic                  req_val_down_in = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_mode;
   logic [HUE_W-1:0]      rsp_hue;
   logic [LVL_W-1:0]      rsp_sat;
   logic [LVL_W-1:0]      rsp_val;
   logic                  rsp_sat_down;
   logic                  rsp_val_down;
   logic [LVL_W-1:0]      rsp_duty;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predicted picker state and its settings
   hcp_pkg::mode_type cur_mode = hcp_pkg::MODE_IDLE;
   logic [HUE_W-1:0]  cur_hue = '0;
   logic [LVL_W-1:0]  cur_sat = '0;
   logic [LVL_W-1:0]  cur_val = '0;
   logic              cur_sat_down = 1'b0;
   logic              cur_val_down = 1'b0;
   logic [CNT_W-1:0]  blink = '0;
   logic [HUE_W-1:0]  cfg_hue_mod = hcp_pkg::HUE_MOD_RST;
   logic [LVL_W-1:0]  cfg_sat_max = hcp_pkg::SAT_MAX_RST;
   logic [LVL_W-1:0]  cfg_val_max = hcp_pkg::VAL_MAX_RST;
   logic [LVL_W-1:0]  cfg_max_duty = hcp_pkg::MAX_DUTY_RST;

   picker_event_type pending_events[$];
   led_view_type     expected_views[$];
   picker_event_type in_flight;
   bit               calm = 1'b0;      // no idling on either side
   int               fail_count = 0;
   int               received = 0;
   int               hold_left = 0;
   int               cycle_count = 0;

   hsv_color_picker_mode_fsm_top dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // Ping-pong step of a level between 0 and top
   function automatic void swing(inout logic [LVL_W-1:0] level, inout logic down,
                                 input logic [LVL_W-1:0] top);
      if ((!down && level >= top) || (down && level == '0)) down = ~down;
      if (down) level = (level != '0) ? level - 1'b1 : '0;
      else level = (level != '1) ? level + 1'b1 : '1;
   endfunction

   // Clamped color write shared by set and load
   function automatic void write_color(input picker_event_type ev);
      logic [HUE_W-1:0] htop;
      htop = (cfg_hue_mod != '0) ? cfg_hue_mod - 1'b1 : '0;
      cur_hue = (ev.hue > htop) ? htop : ev.hue;
      cur_sat = (ev.sat > cfg_sat_max) ? cfg_sat_max : ev.sat;
      cur_val = (ev.val > cfg_val_max) ? cfg_val_max : ev.val;
   endfunction

   // Apply one item to the predicted state and return the view it yields
   function automatic led_view_type advance_picker(input picker_event_type ev);
      led_view_type v;
      int           period;
      int           md;
      int           gap;
      case (ev.kind)
         hcp_pkg::REQ_MODE: begin
            cur_mode = (cur_mode == hcp_pkg::MODE_VAL) ? hcp_pkg::MODE_IDLE
                                                       : hcp_pkg::mode_type'(cur_mode + 1'b1);
            blink = '0;
         end
         hcp_pkg::REQ_STEP: begin
            if (cur_mode == hcp_pkg::MODE_HUE) begin
               cur_hue = ({1'b0, cur_hue} + 10'd1 >= {1'b0, cfg_hue_mod}) ? '0
                         : cur_hue + 1'b1;
            end else if (cur_mode == hcp_pkg::MODE_SAT) begin
               swing(cur_sat, cur_sat_down, cfg_sat_max);
            end else if (cur_mode == hcp_pkg::MODE_VAL) begin
               swing(cur_val, cur_val_down, cfg_val_max);
            end
         end
         hcp_pkg::REQ_TICK: begin
            if (cur_mode == hcp_pkg::MODE_HUE || cur_mode == hcp_pkg::MODE_SAT) begin
               period = 2 * int'(cfg_max_duty);
               blink = (period != 0) ? CNT_W'((int'(blink) + 1) % period) : '0;
            end
         end
         hcp_pkg::REQ_SET: write_color(ev);
         hcp_pkg::REQ_LOAD: begin
            write_color(ev);
            cur_sat_down = ev.sat_down;
            cur_val_down = ev.val_down;
         end
         default: ;
      endcase
      md = int'(cfg_max_duty);
      if (cur_mode == hcp_pkg::MODE_IDLE) begin
         v.duty = '0;
      end else if (cur_mode == hcp_pkg::MODE_VAL) begin
         v.duty = cfg_max_duty;
      end else begin
         gap = (int'(blink) >= md) ? int'(blink) - md : md - int'(blink);
         v.duty = (gap > md) ? '0 : LVL_W'(md - gap);
      end
      v.mode     = cur_mode;
      v.hue      = cur_hue;
      v.sat      = cur_sat;
      v.val      = cur_val;
      v.sat_down = cur_sat_down;
      v.val_down = cur_val_down;
      return v;
   endfunction

   // Request driver: launches queued items, predicts each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_views.push_back(advance_picker(in_flight));
         if (!req_valid || req_ready) begin
            if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               in_flight = pending_events.pop_front();
               req_valid       <= 1'b1;
               req_type        <= in_flight.kind;
               req_hue_in      <= in_flight.hue;
               req_sat_in      <= in_flight.sat;
               req_val_in      <= in_flight.val;
               req_sat_down_in <= in_flight.sat_down;
               req_val_down_in <= in_flight.val_down;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Result monitor: compares each result with the oldest prediction
   always @(posedge clock) begin
      led_view_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               $error("result item with no prediction waiting");
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               check_field("mode", int'(want.mode), int'(rsp_mode));
               check_field("hue", int'(want.hue), int'(rsp_hue));
               check_field("sat", int'(want.sat), int'(rsp_sat));
               check_field("val", int'(want.val), int'(rsp_val));
               check_field("sat_down", int'(want.sat_down), int'(rsp_sat_down));
               check_field("val_down", int'(want.val_down), int'(rsp_val_down));
               check_field("duty", int'(want.duty), int'(rsp_duty));
            end
            received++;
            // long hold-off so the block backs up into its input
            if (received == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic add_event(input logic [REQ_W-1:0] kind, input logic [HUE_W-1:0] hue,
                            input logic [LVL_W-1:0] sat, input logic [LVL_W-1:0] val,
                            input logic sat_down, input logic val_down);
      picker_event_type ev;
      ev.kind = kind;
      ev.hue = hue;
      ev.sat = sat;
      ev.val = val;
      ev.sat_down = sat_down;
      ev.val_down = val_down;
      pending_events.push_back(ev);
   endtask

   // Random fields, often at the extremes
   function automatic picker_event_type random_event(input logic [REQ_W-1:0] kind);
      picker_event_type ev;
      ev.kind = kind;
      ev.hue = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : HUE_W'($urandom);
      ev.sat = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : LVL_W'($urandom);
      ev.val = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : LVL_W'($urandom);
      ev.sat_down = 1'($urandom_range(0, 1));
      ev.val_down = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   // Mostly runs of steps and ticks in one mode, with mode changes, writes and noise
   task automatic add_random_events(input int count);
      int made;
      int r;
      int len;
      logic [REQ_W-1:0] kind;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            len = $urandom_range(5, 120);
            repeat (len) begin
               kind = ($urandom_range(0, 99) < 65) ? hcp_pkg::REQ_STEP : hcp_pkg::REQ_TICK;
               pending_events.push_back(random_event(kind));
            end
            made += len;
         end else if (r < 72) begin
            len = $urandom_range(1, 3);
            repeat (len) pending_events.push_back(random_event(hcp_pkg::REQ_MODE));
            made += len;
         end else if (r < 87) begin
            kind = $urandom_range(0, 1) ? hcp_pkg::REQ_SET : hcp_pkg::REQ_LOAD;
            pending_events.push_back(random_event(kind));
            made++;
         end else begin
            kind = REQ_W'($urandom_range(0, {REQ_W{1'b1}}));
            pending_events.push_back(random_event(kind));
            if (kind <= hcp_pkg::REQ_LOAD) made++;
         end
      end
   endtask

   // Wait until nothing is queued, in flight or predicted
   task automatic drain();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_views.size() != 0);
   endtask

   // Write all four registers, max_duty last, then let the counter reduction finish
   task automatic set_picker_config(input logic [HUE_W-1:0] hm, input logic [LVL_W-1:0] sm,
                                    input logic [LVL_W-1:0] vm, input logic [LVL_W-1:0] md);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= hcp_pkg::CSR_HUE_MOD;
      csr_data  <= hm;
      @(posedge clock);
      csr_index <= hcp_pkg::CSR_SAT_MAX;
      csr_data  <= {1'b0, sm};
      @(posedge clock);
      csr_index <= hcp_pkg::CSR_VAL_MAX;
      csr_data  <= {1'b0, vm};
      @(posedge clock);
      csr_index <= hcp_pkg::CSR_MAX_DUTY;
      csr_data  <= {1'b0, md};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_hue_mod  = hm;
      cfg_sat_max  = sm;
      cfg_val_max  = vm;
      cfg_max_duty = md;
      repeat (SETTLE) @(posedge clock);
   endtask

   // Stimulus and end of run
   initial begin
      int phase;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items at the reset settings
      add_event(hcp_pkg::REQ_SET, '1, '1, '1, 1'b0, 1'b0);       // clamp all three to tops
      add_event(hcp_pkg::REQ_STEP, '0, '0, '0, 1'b0, 1'b0);      // idle: no change
      add_event(hcp_pkg::REQ_TICK, '0, '0, '0, 1'b0, 1'b0);      // idle: counter kept
      add_event(hcp_pkg::REQ_LOAD + 1'b1, '1, '1, '1, 1'b1, 1'b1);  // unknown type
      add_event(hcp_pkg::REQ_MODE, '0, '0, '0, 1'b0, 1'b0);      // to hue
      add_event(hcp_pkg::REQ_STEP, '0, '0, '0, 1'b0, 1'b0);      // hue wraps at modulus
      add_event(hcp_pkg::REQ_TICK, '0, '0, '0, 1'b0, 1'b0);
      add_event(hcp_pkg::REQ_TICK, '0, '0, '0, 1'b0, 1'b0);
      add_event(hcp_pkg::REQ_SET, '0, '0, '0, 1'b1, 1'b1);
      add_event(hcp_pkg::REQ_STEP, '0, '0, '0, 1'b0, 1'b0);
      add_event(hcp_pkg::REQ_MODE, '0, '0, '0, 1'b0, 1'b0);      // to saturation, counter cleared
      add_event(hcp_pkg::REQ_SET, 9'd5, '1, 8'd7, 1'b0, 1'b0);
      add_event(hcp_pkg::REQ_STEP, '0, '0, '0, 1'b0, 1'b0);      // at top while rising: reverse
      add_event(hcp_pkg::REQ_LOAD, 9'd300, '0, '0, 1'b1, 1'b1);  // at zero while falling
      add_event(hcp_pkg::REQ_STEP, '0, '0, '0, 1'b0, 1'b0);
      add_event(hcp_pkg::REQ_TICK, '0, '0, '0, 1'b0, 1'b0);
      add_event(hcp_pkg::REQ_MODE, '0, '0, '0, 1'b0, 1'b0);      // to value
      add_event(hcp_pkg::REQ_STEP, '0, '0, '0, 1'b0, 1'b0);      // value at zero while falling
      add_event(hcp_pkg::REQ_LOAD, '1, '0, '1, 1'b0, 1'b0);
      add_event(hcp_pkg::REQ_STEP, '0, '0, '0, 1'b0, 1'b0);      // value at top while rising
      add_event(hcp_pkg::REQ_TICK, '0, '0, '0, 1'b0, 1'b0);      // value mode: counter kept
      add_event({REQ_W{1'b1}}, '0, '0, '0, 1'b0, 1'b0);          // unknown type
      add_event(hcp_pkg::REQ_MODE, '0, '0, '0, 1'b0, 1'b0);      // wraps to idle
      add_event(hcp_pkg::REQ_LOAD, '0, '1, '0, 1'b1, 1'b0);
      add_random_events(PHASE_ITEMS - 30);

      for (phase = 1; phase < PHASES; phase++) begin
         drain();
         case (phase)
            1: set_picker_config(9'd1, 8'd1, 8'd1, 8'd1);
            2: set_picker_config(9'd511, 8'd255, 8'd255, 8'd255);
            3: set_picker_config(9'd7, 8'd3, 8'd4, 8'd2);
            4: set_picker_config(HUE_W'($urandom_range(1, 511)), LVL_W'($urandom_range(1, 255)),
                                 LVL_W'($urandom_range(1, 255)), LVL_W'($urandom_range(1, 255)));
            5: set_picker_config(9'd2, 8'd255, 8'd1, 8'd255);
            6: set_picker_config(HUE_W'($urandom_range(1, 31)), LVL_W'($urandom_range(1, 15)),
                                 LVL_W'($urandom_range(1, 15)), LVL_W'($urandom_range(1, 15)));
            default: set_picker_config(hcp_pkg::HUE_MOD_RST, hcp_pkg::SAT_MAX_RST,
                                       hcp_pkg::VAL_MAX_RST, hcp_pkg::MAX_DUTY_RST);
         endcase
         @(negedge clock);
         calm = (phase == 4);
         add_random_events(PHASE_ITEMS);
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && expected_views.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
sv/hcp_pkg.sv
sv/hsv_color_picker_mode_fsm_top.sv
tb/sv/tb.sv
